FILE: sv/bitmap_page_frame_allocator_assert.svh
// Assertion macros shared by the page frame allocator RTL.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPFA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page frame allocator check failed");

// Consequent must hold in the cycle after the antecedent.
`define BPFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page frame allocator check failed");

`endif

FILE: sv/bpfa_pkg.sv
// Types, constants and helper functions of the bitmap page frame allocator.
`default_nettype none
package bpfa_pkg;

  localparam int NUM_RANGES      = 2;
  localparam int PAGES_PER_RANGE = 1024;
  localparam int PAGE_W          = 20;
  localparam int WORD_BITS       = 32;
  localparam int WORDS_PER_RANGE = (PAGES_PER_RANGE + WORD_BITS - 1) / WORD_BITS;
  localparam int RANGE_W         = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int WORD_W          = (WORDS_PER_RANGE > 1) ? $clog2(WORDS_PER_RANGE) : 1;
  localparam int BIT_W           = $clog2(WORD_BITS);
  localparam int OFF_W           = WORD_W + BIT_W;
  localparam int MEM_AW          = RANGE_W + WORD_W;
  localparam int MEM_DEPTH       = 2 ** MEM_AW;
  localparam int CNT_W           = 11;
  localparam int ACT_W           = 2;
  localparam int APB_AW          = 5;
  localparam int APB_DW          = 32;

  localparam logic [WORD_BITS-1:0] TOP_BIT = 32'h8000_0000;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NO_FREE      = 2'd1;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

  // Register indexes, one 32-bit word each.
  localparam logic [2:0] REG_R0_BASE  = 3'd0;
  localparam logic [2:0] REG_R0_COUNT = 3'd1;
  localparam logic [2:0] REG_R1_BASE  = 3'd2;
  localparam logic [2:0] REG_R1_COUNT = 3'd3;
  localparam logic [2:0] REG_RANGES   = 3'd4;

  typedef struct packed {
    logic              opcode;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] result_page;
    logic [1:0]        status;
  } rsp_t;

  // Control from the sequencer to the bitmap store.
  typedef struct packed {
    logic [MEM_AW-1:0]    rd_addr;
    logic                 wr_en;
    logic [MEM_AW-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 clr_en;
    logic [RANGE_W-1:0]   clr_range;
  } bm_req_t;

  // Position of the most significant set bit, counted from the top (lowest page offset).
  function automatic logic [BIT_W-1:0] first_free(input logic [WORD_BITS-1:0] word);
    logic [WORD_BITS-1:0] v;
    logic [BIT_W-1:0]     n;
    v = word;
    n = '0;
    if (v[31:16] == 16'd0) begin
      n[4] = 1'b1;
      v = v << 16;
    end
    if (v[31:24] == 8'd0) begin
      n[3] = 1'b1;
      v = v << 8;
    end
    if (v[31:28] == 4'd0) begin
      n[2] = 1'b1;
      v = v << 4;
    end
    if (v[31:30] == 2'd0) begin
      n[1] = 1'b1;
      v = v << 2;
    end
    if (v[31] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: sv/bpfa_bitmap.sv
// Free-page bitmap store: one word memory with per-word valid bits and a registered read.
`default_nettype none
module bpfa_bitmap
  import bpfa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bm_req_t              req,
  output logic [WORD_BITS-1:0]      rd_word
);

  logic [WORD_BITS-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vbits;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

  // A word that has not been written since reset or since its range was set up reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= vbits[req.rd_addr];
      if (req.clr_en) begin
        for (int w = 0; w < WORDS_PER_RANGE; w++) begin
          vbits[{req.clr_range, WORD_W'(w)}] <= 1'b0;
        end
      end else if (req.wr_en) begin
        vbits[req.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_word = rd_valid ? rd_data : '0;

endmodule
`default_nettype wire

FILE: sv/bitmap_page_frame_allocator.sv
// Bitmap page frame allocator over two configurable page ranges.
// Free: checks the ranges in turn from range 0, then reads and updates the bitmap word on a hit.
// Allocate: visits the ranges from the highest down, with one selection step per range and a
// word-by-word scan of its bitmap by the shared priority encoder.
// One transaction at a time: the next is accepted in the cycle after its result is registered.
// Synchronous reset: every page taken, all free counts and registers zero, no clearing pass.
`default_nettype none
`include "bitmap_page_frame_allocator_assert.svh"
module bitmap_page_frame_allocator
  import bpfa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire req_t              req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output rsp_t                   rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FCHK  = 3'd1;
  localparam logic [2:0] S_FRD   = 3'd2;
  localparam logic [2:0] S_ASEL  = 3'd3;
  localparam logic [2:0] S_ASCAN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           state;
  logic [PAGE_W-1:0]    range_base [NUM_RANGES];
  logic [CNT_W-1:0]     range_count [NUM_RANGES];
  logic [ACT_W-1:0]     ranges_in_use;
  logic [CNT_W-1:0]     free_cnt [NUM_RANGES];
  logic [PAGE_W-1:0]    page_q;
  logic [RANGE_W-1:0]   ridx;
  logic [OFF_W-1:0]     hit_off;
  logic [WORD_W-1:0]    dw;
  logic [PAGE_W-1:0]    res_page;
  logic [1:0]           res_status;

  logic                 cfg_wr;
  logic [2:0]           cfg_idx;
  logic [ACT_W-1:0]     act;
  logic [RANGE_W-1:0]   last_idx;
  logic [CNT_W-1:0]     eff_cnt;
  logic [WORD_W:0]      num_words;
  logic                 last_word;
  logic [PAGE_W:0]      diff;
  logic                 hit;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] bit_mask;
  logic [BIT_W-1:0]     lead;
  logic [WORD_BITS-1:0] lead_mask;
  bm_req_t              bm_req;

  assign req_ready = (state == S_IDLE);
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_idx   = paddr[4:2];

  assign act      = (ranges_in_use > ACT_W'(NUM_RANGES)) ? ACT_W'(NUM_RANGES) : ranges_in_use;
  assign last_idx = RANGE_W'(act - ACT_W'(1));

  // Counts above the bitmap size saturate to the bitmap size.
  assign eff_cnt   = (range_count[ridx] > CNT_W'(PAGES_PER_RANGE)) ?
                     CNT_W'(PAGES_PER_RANGE) : range_count[ridx];
  assign num_words = (WORD_W + 1)'(({1'b0, eff_cnt} + (CNT_W + 1)'(WORD_BITS - 1)) >> BIT_W);
  assign last_word = ({1'b0, dw} + (WORD_W + 1)'(1)) >= num_words;

  assign diff = {1'b0, page_q} - {1'b0, range_base[ridx]};
  assign hit  = !diff[PAGE_W] && (diff[PAGE_W-1:0] < PAGE_W'(eff_cnt));

  assign bit_mask  = TOP_BIT >> hit_off[BIT_W-1:0];
  assign lead      = first_free(rd_word);
  assign lead_mask = TOP_BIT >> lead;

  always_comb begin
    bm_req           = '0;
    bm_req.clr_en    = cfg_wr && (cfg_idx == REG_R0_BASE || cfg_idx == REG_R0_COUNT ||
                                  cfg_idx == REG_R1_BASE || cfg_idx == REG_R1_COUNT);
    bm_req.clr_range = RANGE_W'(cfg_idx[2:1]);
    case (state)
      S_FCHK: begin
        bm_req.rd_addr = {ridx, diff[OFF_W-1:BIT_W]};
      end
      S_FRD: begin
        bm_req.rd_addr = {ridx, hit_off[OFF_W-1:BIT_W]};
        bm_req.wr_addr = {ridx, hit_off[OFF_W-1:BIT_W]};
        bm_req.wr_data = rd_word | bit_mask;
        bm_req.wr_en   = ((rd_word & bit_mask) == '0);
      end
      S_ASEL: begin
        bm_req.rd_addr = {ridx, WORD_W'(0)};
      end
      S_ASCAN: begin
        bm_req.rd_addr = {ridx, dw + WORD_W'(1)};
        bm_req.wr_addr = {ridx, dw};
        bm_req.wr_data = rd_word & ~lead_mask;
        bm_req.wr_en   = (rd_word != '0);
      end
      default: begin
        bm_req.rd_addr = {ridx, WORD_W'(0)};
      end
    endcase
  end

  bpfa_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .req     (bm_req),
    .rd_word (rd_word)
  );

  always_comb begin
    case (cfg_idx)
      REG_R0_BASE:  prdata = APB_DW'(range_base[0]);
      REG_R0_COUNT: prdata = APB_DW'(range_count[0]);
      REG_R1_BASE:  prdata = APB_DW'(range_base[1]);
      REG_R1_COUNT: prdata = APB_DW'(range_count[1]);
      REG_RANGES:   prdata = APB_DW'(ranges_in_use);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rsp_valid     <= 1'b0;
      ranges_in_use <= '0;
      ridx          <= '0;
      for (int r = 0; r < NUM_RANGES; r++) begin
        range_base[r]  <= '0;
        range_count[r] <= '0;
        free_cnt[r]    <= '0;
      end
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_R0_BASE: begin
            range_base[0] <= pwdata[PAGE_W-1:0];
            free_cnt[0]   <= '0;
          end
          REG_R0_COUNT: begin
            range_count[0] <= pwdata[CNT_W-1:0];
            free_cnt[0]    <= '0;
          end
          REG_R1_BASE: begin
            range_base[1] <= pwdata[PAGE_W-1:0];
            free_cnt[1]   <= '0;
          end
          REG_R1_COUNT: begin
            range_count[1] <= pwdata[CNT_W-1:0];
            free_cnt[1]    <= '0;
          end
          REG_RANGES: begin
            ranges_in_use <= pwdata[ACT_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            page_q   <= req.page_number;
            res_page <= '0;
            if (req.opcode == OP_FREE) begin
              ridx <= '0;
              if (act == '0) begin
                res_status <= ST_OUT_OF_RANGE;
                state      <= S_DONE;
              end else begin
                state <= S_FCHK;
              end
            end else begin
              ridx <= last_idx;
              if (act == '0) begin
                res_status <= ST_NO_FREE;
                state      <= S_DONE;
              end else begin
                state <= S_ASEL;
              end
            end
          end
        end
        S_FCHK: begin
          if (hit) begin
            hit_off <= diff[OFF_W-1:0];
            state   <= S_FRD;
          end else if (ridx == last_idx) begin
            res_status <= ST_OUT_OF_RANGE;
            state      <= S_DONE;
          end else begin
            ridx <= ridx + RANGE_W'(1);
          end
        end
        S_FRD: begin
          // Freeing a page that is already free changes nothing.
          if ((rd_word & bit_mask) == '0) begin
            free_cnt[ridx] <= free_cnt[ridx] + CNT_W'(1);
          end
          res_status <= ST_OK;
          state      <= S_DONE;
        end
        S_ASEL: begin
          if (free_cnt[ridx] != '0) begin
            dw    <= '0;
            state <= S_ASCAN;
          end else if (ridx == '0) begin
            res_status <= ST_NO_FREE;
            state      <= S_DONE;
          end else begin
            ridx <= ridx - RANGE_W'(1);
          end
        end
        S_ASCAN: begin
          if (rd_word != '0) begin
            free_cnt[ridx] <= free_cnt[ridx] - CNT_W'(1);
            res_page       <= range_base[ridx] + PAGE_W'({dw, lead});
            res_status     <= ST_OK;
            state          <= S_DONE;
          end else if (!last_word) begin
            dw <= dw + WORD_W'(1);
          end else if (ridx == '0) begin
            res_status <= ST_NO_FREE;
            state      <= S_DONE;
          end else begin
            ridx  <= ridx - RANGE_W'(1);
            state <= S_ASEL;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.result_page <= res_page;
            rsp.status      <= res_status;
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BPFA_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state != S_IDLE)
  `BPFA_ASSERT_SAME(a_write_only_in_update, bm_req.wr_en, state == S_FRD || state == S_ASCAN)
  `BPFA_ASSERT_SAME(a_free_count_bound, 1'b1, free_cnt[0] <= CNT_W'(PAGES_PER_RANGE) && free_cnt[NUM_RANGES-1] <= CNT_W'(PAGES_PER_RANGE))
  `BPFA_ASSERT_SAME(a_result_from_done, $rose(rsp_valid), $past(state) == S_DONE)

endmodule
`default_nettype wire
